[rtl/core/arpc_pkg.sv]
// Types and constants shared by the ARP cache with request retry.
`timescale 1ns / 1ps

package arpc_pkg;

	// Table sizes
	localparam int CACHE_ENTRIES   = 16;
	localparam int REQUEST_ENTRIES = 8;
	localparam int CIDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int RIDX_W = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;

	// Field widths
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int IFACE_W = 2;
	localparam int AGE_W   = 8;
	localparam int WAIT_W  = 4;
	localparam int SENDS_W = 4;
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 88;

	// Saturation limits and start values
	localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
	localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
	localparam logic [SENDS_W-1:0] SENDS_MAX = '1;

	// Configuration register indexes and reset values
	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_GAP     = 2'd2;
	localparam logic [7:0]  TIMEOUT_RST = 8'd15;
	localparam logic [3:0]  LIMIT_RST   = 4'd5;
	localparam logic [3:0]  GAP_RST     = 4'd1;

	// Input commands
	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_QUEUE  = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_LOOKUP = 3'd0,
		KIND_INSERT = 3'd1,
		KIND_QUEUE  = 3'd2,
		KIND_SEND   = 3'd3,
		KIND_GIVEUP = 3'd4,
		KIND_DONE   = 3'd5
	} kind_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CSCAN,
		ST_RSCAN,
		ST_SWEEP,
		ST_FINISH
	} st_t;

endpackage

[rtl/core/arp_cache_with_request_retry.sv]
// ARP cache with entry aging and a retried address-request table.
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// s_        in         s_tvalid/s_tready   s_tuser cmd, s_tdata ip/mac/iface
// m_        out        m_tvalid/m_tready   m_tuser kind, m_tdata, m_tlast
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item at a time; a sequencer walks the tables one entry per cycle,
// except while a sweep waits on a full result register. Lookup walks the
// cache, queue the request table, insert the request table then the cache,
// and tick the cache then sweeps the request table; each ends in ST_FINISH.
// arst_n clears valid marks, the sequencer and the registers to defaults.
// A stalled m_ side holds the walk at the entry that has a result to give.

module arp_cache_with_request_retry (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [arpc_pkg::IN_DATA_W-1:0]    s_tdata,   // ip[31:0] mac[79:32] iface[81:80]
	input  logic [1:0]                        s_tuser,   // cmd[1:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [arpc_pkg::OUT_DATA_W-1:0]   m_tdata,   // addr_ip[31:0] addr_mac[79:32]
	                                                     // hit[80] stored[81] out_iface[83:82]
	output logic [2:0]                        m_tuser,   // kind[2:0]
	output logic                              m_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [7:0]                        cfg_data
);
	import arpc_pkg::*;

	// Configuration registers
	logic [AGE_W-1:0]   timeout_q;
	logic [SENDS_W-1:0] limit_q;
	logic [WAIT_W-1:0]  gap_q;

	// Tables
	logic [CACHE_ENTRIES-1:0]   ev_q;
	logic [IP_W-1:0]            eip_q   [CACHE_ENTRIES];
	logic [MAC_W-1:0]           emac_q  [CACHE_ENTRIES];
	logic [AGE_W-1:0]           eage_q  [CACHE_ENTRIES];
	logic [REQUEST_ENTRIES-1:0] rv_q;
	logic [IP_W-1:0]            rip_q   [REQUEST_ENTRIES];
	logic [IFACE_W-1:0]         rif_q   [REQUEST_ENTRIES];
	logic [SENDS_W-1:0]         rsends_q[REQUEST_ENTRIES];
	logic [WAIT_W-1:0]          rwait_q [REQUEST_ENTRIES];

	// Sequencer and working registers
	st_t                state_q, state_d;
	cmd_t               cmd_q;
	logic [IP_W-1:0]    ip_q;
	logic [MAC_W-1:0]   mac_q;
	logic [IFACE_W-1:0] iface_q;
	logic [CIDX_W-1:0]  cidx_q;
	logic [RIDX_W-1:0]  ridx_q;
	logic               hit_q;
	logic               free_q;
	logic [RIDX_W-1:0]  r_idx_q;
	logic [RIDX_W-1:0]  rfree_idx_q;
	logic [IFACE_W-1:0] r_iface_q;
	logic [MAC_W-1:0]   res_mac_q;

	// Result register
	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [IP_W-1:0]    out_ip_q;
	logic [MAC_W-1:0]   out_mac_q;
	logic               out_hit_q, out_stored_q, out_last_q;
	logic [IFACE_W-1:0] out_iface_q;

	// Combinational controls
	logic               in_acc, out_free, out_load;
	logic               c_last, r_last, c_match, r_match;
	logic [AGE_W-1:0]   c_age_inc;
	logic [WAIT_W-1:0]  r_wait_inc;
	logic               r_due, r_give, sweep_emit, sweep_go, finish_go;
	kind_t              o_kind;
	logic [IP_W-1:0]    o_ip;
	logic [MAC_W-1:0]   o_mac;
	logic               o_hit, o_stored, o_last;
	logic [IFACE_W-1:0] o_iface;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	// Current table entries under the walk counters
	assign c_last     = (cidx_q == CIDX_W'(CACHE_ENTRIES - 1));
	assign r_last     = (ridx_q == RIDX_W'(REQUEST_ENTRIES - 1));
	assign c_match    = ev_q[cidx_q] && (eip_q[cidx_q] == ip_q);
	assign r_match    = rv_q[ridx_q] && (rip_q[ridx_q] == ip_q);
	assign c_age_inc  = (eage_q[cidx_q] == AGE_MAX) ? AGE_MAX : eage_q[cidx_q] + AGE_W'(1);
	assign r_wait_inc = (rwait_q[ridx_q] == WAIT_MAX) ? WAIT_MAX
	                                                  : rwait_q[ridx_q] + WAIT_W'(1);
	assign r_due      = r_wait_inc > gap_q;
	assign r_give     = rsends_q[ridx_q] >= limit_q;
	assign sweep_emit = (state_q == ST_SWEEP) && rv_q[ridx_q] && r_due;
	assign sweep_go   = (state_q == ST_SWEEP) && (!sweep_emit || out_free);
	assign finish_go  = (state_q == ST_FINISH) && out_free;

	// Next state and result selection
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		o_kind   = KIND_DONE;
		o_ip     = '0;
		o_mac    = '0;
		o_hit    = 1'b0;
		o_stored = 1'b0;
		o_iface  = '0;
		o_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (cmd_t'(s_tuser))
						CMD_LOOKUP, CMD_TICK: state_d = ST_CSCAN;
						default:              state_d = ST_RSCAN;
					endcase
				end
			end
			ST_CSCAN: begin
				if (c_last) begin
					state_d = (cmd_q == CMD_TICK) ? ST_SWEEP : ST_FINISH;
				end
			end
			ST_RSCAN: begin
				if (r_last) begin
					state_d = (cmd_q == CMD_INSERT) ? ST_CSCAN : ST_FINISH;
				end
			end
			ST_SWEEP: begin
				o_kind  = r_give ? KIND_GIVEUP : KIND_SEND;
				o_ip    = rip_q[ridx_q];
				o_iface = rif_q[ridx_q];
				o_last  = 1'b0;
				out_load = sweep_emit && out_free;
				if (sweep_go && r_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				out_load = out_free;
				o_ip     = ip_q;
				case (cmd_q)
					CMD_LOOKUP: begin
						o_kind = KIND_LOOKUP;
						o_hit  = hit_q;
						o_mac  = hit_q ? res_mac_q : '0;
					end
					CMD_INSERT: begin
						o_kind   = KIND_INSERT;
						o_hit    = hit_q;
						o_stored = free_q;
						o_iface  = r_iface_q;
					end
					CMD_QUEUE: begin
						o_kind   = KIND_QUEUE;
						o_hit    = hit_q;
						o_stored = !hit_q && free_q;
					end
					default: begin
						o_kind = KIND_DONE;
						o_ip   = '0;
					end
				endcase
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			limit_q   <= LIMIT_RST;
			gap_q     <= GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TIMEOUT: timeout_q <= cfg_data;
				CFG_LIMIT:   limit_q   <= cfg_data[SENDS_W-1:0];
				CFG_GAP:     gap_q     <= cfg_data[WAIT_W-1:0];
				default:     ;
			endcase
		end
	end

	// Walk counters and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q <= '0;
			ridx_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else begin
			if (in_acc) begin
				cidx_q <= '0;
				ridx_q <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			if (state_q == ST_CSCAN) begin
				cidx_q <= c_last ? '0 : cidx_q + CIDX_W'(1);
				if (cmd_q == CMD_LOOKUP && c_match) begin
					hit_q <= 1'b1;
				end
				if (cmd_q == CMD_INSERT && !ev_q[cidx_q] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == ST_RSCAN) begin
				ridx_q <= r_last ? '0 : ridx_q + RIDX_W'(1);
				if (r_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (cmd_q == CMD_QUEUE && !rv_q[ridx_q] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (sweep_go) begin
				ridx_q <= r_last ? '0 : ridx_q + RIDX_W'(1);
			end
		end
	end

	// Item payload and found-entry details
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q     <= cmd_t'(s_tuser);
			ip_q      <= s_tdata[IP_W-1:0];
			mac_q     <= s_tdata[IP_W+MAC_W-1:IP_W];
			iface_q   <= s_tdata[IP_W+MAC_W+IFACE_W-1:IP_W+MAC_W];
			r_iface_q <= '0;
		end
		if (state_q == ST_CSCAN && cmd_q == CMD_LOOKUP && c_match) begin
			res_mac_q <= emac_q[cidx_q];
		end
		if (state_q == ST_RSCAN && r_match && !hit_q) begin
			r_idx_q   <= ridx_q;
			r_iface_q <= rif_q[ridx_q];
		end
		if (state_q == ST_RSCAN && !rv_q[ridx_q] && !free_q) begin
			rfree_idx_q <= ridx_q;
		end
	end

	// Valid marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= '0;
			rv_q <= '0;
		end else begin
			if (state_q == ST_CSCAN) begin
				if (cmd_q == CMD_INSERT && !ev_q[cidx_q] && !free_q) begin
					ev_q[cidx_q] <= 1'b1;
				end
				if (cmd_q == CMD_TICK && ev_q[cidx_q] && c_age_inc > timeout_q) begin
					ev_q[cidx_q] <= 1'b0;
				end
			end
			// insert retires the lowest matching request
			if (state_q == ST_RSCAN && cmd_q == CMD_INSERT && r_match && !hit_q) begin
				rv_q[ridx_q] <= 1'b0;
			end
			if (sweep_go && sweep_emit && r_give) begin
				rv_q[ridx_q] <= 1'b0;
			end
			if (finish_go && cmd_q == CMD_QUEUE && !hit_q && free_q) begin
				rv_q[rfree_idx_q] <= 1'b1;
			end
		end
	end

	// Table contents
	always_ff @(posedge clk) begin
		if (state_q == ST_CSCAN) begin
			if (cmd_q == CMD_INSERT && !ev_q[cidx_q] && !free_q) begin
				eip_q[cidx_q]  <= ip_q;
				emac_q[cidx_q] <= mac_q;
				eage_q[cidx_q] <= '0;
			end
			if (cmd_q == CMD_TICK && ev_q[cidx_q]) begin
				eage_q[cidx_q] <= c_age_inc;
			end
		end
		if (sweep_go && rv_q[ridx_q]) begin
			if (sweep_emit && !r_give) begin
				rwait_q[ridx_q] <= '0;
				if (rsends_q[ridx_q] != SENDS_MAX) begin
					rsends_q[ridx_q] <= rsends_q[ridx_q] + SENDS_W'(1);
				end
			end else begin
				rwait_q[ridx_q] <= r_wait_inc;
			end
		end
		if (finish_go && cmd_q == CMD_QUEUE) begin
			if (hit_q) begin
				rif_q[r_idx_q] <= iface_q;
			end else if (free_q) begin
				rip_q[rfree_idx_q]    <= ip_q;
				rif_q[rfree_idx_q]    <= iface_q;
				rsends_q[rfree_idx_q] <= '0;
				rwait_q[rfree_idx_q]  <= WAIT_MAX;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= o_kind;
			out_ip_q     <= o_ip;
			out_mac_q    <= o_mac;
			out_hit_q    <= o_hit;
			out_stored_q <= o_stored;
			out_iface_q  <= o_iface;
			out_last_q   <= o_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {4'b0000, out_iface_q, out_stored_q, out_hit_q, out_mac_q, out_ip_q};

endmodule
